[hdl/checked_signed_alu_unit_macros.svh]
// assertion macros for the checked signed alu unit
// used by the rtl files that carry concurrent checks
`ifndef CHECKED_SIGNED_ALU_UNIT_MACROS_SVH
`define CHECKED_SIGNED_ALU_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hdl/csa_pkg.sv]
// shared types and constants for the checked signed alu unit
// no dependencies
`default_nettype none
package csa_pkg;
	localparam int DATA_W    = 32;
	localparam int DIV_STEPS = DATA_W;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_REM = 3'd4
	} cmd_t;

	// fields that ride alongside the divider datapath
	typedef struct packed {
		logic [2:0]        cmd;
		logic              alt_ok;
		logic [DATA_W-1:0] alt_val;
		logic              neg_q;
		logic              neg_r;
		logic              div_bad;
	} side_t;
endpackage
`default_nettype wire

[hdl/csa_divider.sv]
// unsigned restoring divider, one quotient bit per pipeline stage
// depends on csa_pkg
`default_nettype none
module csa_divider
	import csa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_vld,
	input  wire side_t             in_side,
	input  wire logic [DATA_W-1:0] in_dvd,
	input  wire logic [DATA_W-1:0] in_dsr,
	output logic                   out_vld,
	output side_t                  out_side,
	output logic [DATA_W-1:0]      out_quo,
	output logic [DATA_W-1:0]      out_rem
);
	logic              vld_s  [0:DIV_STEPS];
	side_t             side_s [0:DIV_STEPS];
	logic [DATA_W-1:0] rem_s  [0:DIV_STEPS];
	logic [DATA_W-1:0] dvd_s  [0:DIV_STEPS];
	logic [DATA_W-1:0] dsr_s  [0:DIV_STEPS];

	assign vld_s[0]  = in_vld;
	assign side_s[0] = in_side;
	assign rem_s[0]  = '0;
	assign dvd_s[0]  = in_dvd;
	assign dsr_s[0]  = in_dsr;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [DATA_W:0] trial;
		logic [DATA_W:0] shifted;
		assign shifted = {rem_s[i], dvd_s[i][DATA_W-1]};
		assign trial   = shifted - {1'b0, dsr_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[i+1] <= side_s[i];
				dsr_s[i+1]  <= dsr_s[i];
				// quotient bit shifts in where the dividend bit left
				if (!trial[DATA_W]) begin
					rem_s[i+1] <= trial[DATA_W-1:0];
					dvd_s[i+1] <= {dvd_s[i][DATA_W-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= shifted[DATA_W-1:0];
					dvd_s[i+1] <= {dvd_s[i][DATA_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld  = vld_s[DIV_STEPS];
	assign out_side = side_s[DIV_STEPS];
	assign out_quo  = dvd_s[DIV_STEPS];
	assign out_rem  = rem_s[DIV_STEPS];
endmodule
`default_nettype wire

[hdl/checked_signed_alu_unit.sv]
// checked signed alu unit
// input channel: in_valid/in_stall with cmd, lhs, rhs; one transfer per item
// output channel: out_valid/out_stall with value, ok; one transfer per item
// cmd selects add, subtract, multiply, divide or remainder on signed 32-bit
// operands; ok is 0 on overflow, zero divisor, minimum by minus one or an
// unused code, and value is then 0
// every operation goes through the same 35 register stages: input register,
// operand stage with the 32x32 multiplier, 32 divider stages of one quotient
// bit each, and the result register
// throughput is one item per cycle unless out_stall holds a waiting result; results leave in input order
// the whole pipeline advances together when the result register is empty or
// being taken; while out_stall holds a waiting result, in_stall is high and
// nothing moves
// reset clears all valid bits, so in_stall is low and the block is ready when reset ends
// depends on csa_pkg, csa_divider and the assertion macro header
`include "checked_signed_alu_unit_macros.svh"
`default_nettype none
module checked_signed_alu_unit
	import csa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        cmd,
	input  wire logic [DATA_W-1:0] lhs,
	input  wire logic [DATA_W-1:0] rhs,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [DATA_W-1:0]      value,
	output logic                   ok
);
	localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// stage 1: operand register
	logic              vld_s1;
	logic [2:0]        cmd_s1;
	logic [DATA_W-1:0] lhs_s1, rhs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd;
			lhs_s1 <= lhs;
			rhs_s1 <= rhs;
		end
	end

	// stage 2: wide sum, difference, product and divider prep
	logic                  vld_s2;
	logic [2:0]            cmd_s2;
	logic [DATA_W:0]       sum_s2, diff_s2;
	logic [2*DATA_W-1:0]   prod_s2;
	logic [DATA_W-1:0]     abs_a_s2, abs_b_s2;
	logic                  neg_q_s2, neg_r_s2, div_bad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2     <= cmd_s1;
			sum_s2     <= {lhs_s1[DATA_W-1], lhs_s1} + {rhs_s1[DATA_W-1], rhs_s1};
			diff_s2    <= {lhs_s1[DATA_W-1], lhs_s1} - {rhs_s1[DATA_W-1], rhs_s1};
			prod_s2    <= (2*DATA_W)'($signed(lhs_s1) * $signed(rhs_s1));
			abs_a_s2   <= lhs_s1[DATA_W-1] ? (~lhs_s1 + 1'b1) : lhs_s1;
			abs_b_s2   <= rhs_s1[DATA_W-1] ? (~rhs_s1 + 1'b1) : rhs_s1;
			neg_q_s2   <= lhs_s1[DATA_W-1] ^ rhs_s1[DATA_W-1];
			neg_r_s2   <= lhs_s1[DATA_W-1];
			div_bad_s2 <= (rhs_s1 == '0) || ((lhs_s1 == INT_MIN) && (rhs_s1 == '1));
		end
	end

	// range checks for add, subtract and multiply
	side_t side_in;
	logic  mul_fit;
	assign mul_fit = (prod_s2[2*DATA_W-1:DATA_W-1] == '0)
		|| (prod_s2[2*DATA_W-1:DATA_W-1] == '1);

	always_comb begin
		side_in         = '0;
		side_in.cmd     = cmd_s2;
		side_in.neg_q   = neg_q_s2;
		side_in.neg_r   = neg_r_s2;
		side_in.div_bad = div_bad_s2;
		case (cmd_s2)
			CMD_ADD: begin
				side_in.alt_ok  = (sum_s2[DATA_W] == sum_s2[DATA_W-1]);
				side_in.alt_val = sum_s2[DATA_W-1:0];
			end
			CMD_SUB: begin
				side_in.alt_ok  = (diff_s2[DATA_W] == diff_s2[DATA_W-1]);
				side_in.alt_val = diff_s2[DATA_W-1:0];
			end
			CMD_MUL: begin
				side_in.alt_ok  = mul_fit;
				side_in.alt_val = prod_s2[DATA_W-1:0];
			end
			default: begin
				side_in.alt_ok  = 1'b0;
				side_in.alt_val = '0;
			end
		endcase
	end

	logic              div_vld;
	side_t             div_side;
	logic [DATA_W-1:0] div_quo, div_rem;

	csa_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (vld_s2),
		.in_side  (side_in),
		.in_dvd   (abs_a_s2),
		.in_dsr   (abs_b_s2),
		.out_vld  (div_vld),
		.out_side (div_side),
		.out_quo  (div_quo),
		.out_rem  (div_rem)
	);

	// result select and sign fix
	logic              res_ok;
	logic [DATA_W-1:0] res_val;

	always_comb begin
		case (div_side.cmd)
			CMD_DIV: begin
				res_ok  = !div_side.div_bad;
				res_val = div_side.neg_q ? (~div_quo + 1'b1) : div_quo;
			end
			CMD_REM: begin
				res_ok  = !div_side.div_bad;
				res_val = div_side.neg_r ? (~div_rem + 1'b1) : div_rem;
			end
			default: begin
				res_ok  = div_side.alt_ok;
				res_val = div_side.alt_val;
			end
		endcase
		if (!res_ok) begin
			res_val = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value <= res_val;
			ok    <= res_ok;
		end
	end

	`CSA_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && !ok, value == '0, "error result not zero")
	`CSA_ASSERT_NXT(a_hold_res, clk, arst_n, out_valid && out_stall, out_valid && $stable(value) && $stable(ok), "stalled result changed")
	`CSA_ASSERT_NXT(a_freeze, clk, arst_n, !adv, $stable(vld_s1) && $stable(vld_s2), "pipeline moved during stall")
	`CSA_ASSERT_IMP(a_stall_src, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without output back pressure")
endmodule
`default_nettype wire

[bench/testbench.sv]
// self-checking bench for the checked signed alu unit
// depends on csa_pkg and checked_signed_alu_unit; predicts every result and checks in order
`default_nettype none
module testbench;
	import csa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = 35;
	localparam int CYCLE_CAP = 400000;
	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] MINUS_ONE = 32'hffff_ffff;

	typedef struct packed {
		logic [31:0] value;
		logic        ok;
	} alu_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  cmd = 3'd0;
	logic [31:0] lhs = '0;
	logic [31:0] rhs = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] value;
	logic        ok;

	alu_result_t pending_results[$];
	int  error_count = 0;
	int  sent_count = 0;
	int  checked_count = 0;
	int  cycle_count = 0;
	int  hold_off_cycles = 0;
	bit  random_stall = 1'b0;

	checked_signed_alu_unit dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .lhs(lhs), .rhs(rhs), .out_valid(out_valid),
		.out_stall(out_stall), .value(value), .ok(ok)
	);

	always #10 clk = ~clk;

	// golden arithmetic with 64-bit range checks
	function automatic alu_result_t alu_predict(logic [2:0] op, logic [31:0] a, logic [31:0] b);
		alu_result_t res;
		longint sa;
		longint sb;
		longint full;
		sa = longint'($signed(a));
		sb = longint'($signed(b));
		full = 0;
		res.ok = 1'b0;
		case (op)
			CMD_ADD: begin
				full = sa + sb;
				res.ok = full >= -64'sd2147483648 && full <= 64'sd2147483647;
			end
			CMD_SUB: begin
				full = sa - sb;
				res.ok = full >= -64'sd2147483648 && full <= 64'sd2147483647;
			end
			CMD_MUL: begin
				full = sa * sb;
				res.ok = full >= -64'sd2147483648 && full <= 64'sd2147483647;
			end
			CMD_DIV, CMD_REM: begin
				if (sb != 0 && !(a == INT_MIN && b == MINUS_ONE)) begin
					full = (op == CMD_DIV) ? sa / sb : sa % sb;
					res.ok = 1'b1;
				end
			end
			default: res.ok = 1'b0;
		endcase
		res.value = res.ok ? full[31:0] : 32'd0;
		return res;
	endfunction

	// valid stays high after a transfer; it drops only when a gap follows
	task automatic send_op(logic [2:0] op, logic [31:0] a, logic [31:0] b);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		lhs <= a;
		rhs <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(alu_predict(op, a, b));
		sent_count++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return INT_MIN;
			1: return INT_MAX;
			2: return MINUS_ONE;
			3: return 32'd0;
			4: return 32'($signed($urandom_range(0, 40)) - 20);
			5: return 32'($urandom_range(0, 32'h0001_ffff)) ^ {32{$urandom_range(0, 1) == 1}};
			default: return $urandom;
		endcase
	endfunction

	// receiver: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			out_stall <= 1'b1;
			hold_off_cycles <= hold_off_cycles - 1;
		end else if (random_stall)
			out_stall <= ($urandom_range(0, 6) > 3);
		else
			out_stall <= 1'b0;
	end

	// result checker
	always @(posedge clk) begin
		alu_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected transfer value %h ok %b", $time, value, ok);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (value !== want.value) begin
					$display("%0t: value expected %h actual %h", $time, want.value, value);
					error_count++;
				end
				if (ok !== want.ok) begin
					$display("%0t: ok expected %b actual %b", $time, want.ok, ok);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic test_directed_corners();
		logic [31:0] corners[6];
		corners = '{INT_MIN, INT_MAX, MINUS_ONE, 32'd0, 32'd1, 32'hffff_fff9};
		send_op(CMD_ADD, INT_MAX, 32'd1);
		send_op(CMD_ADD, INT_MIN, MINUS_ONE);
		send_op(CMD_ADD, INT_MAX, INT_MIN);
		send_op(CMD_SUB, INT_MIN, 32'd1);
		send_op(CMD_SUB, 32'd0, INT_MIN);
		send_op(CMD_SUB, MINUS_ONE, INT_MIN);
		send_op(CMD_MUL, INT_MIN, 32'd0);
		send_op(CMD_MUL, 32'd0, INT_MAX);
		send_op(CMD_MUL, INT_MIN, MINUS_ONE);
		send_op(CMD_MUL, INT_MIN, 32'd1);
		send_op(CMD_MUL, 32'd65536, 32'd32768);
		send_op(CMD_MUL, 32'hffff_0000, 32'd32768);
		send_op(CMD_DIV, INT_MIN, MINUS_ONE);
		send_op(CMD_REM, INT_MIN, MINUS_ONE);
		send_op(CMD_DIV, 32'd5, 32'd0);
		send_op(CMD_REM, INT_MIN, 32'd0);
		send_op(CMD_DIV, 32'hffff_fff9, 32'd2);
		send_op(CMD_REM, 32'hffff_fff9, 32'd2);
		send_op(CMD_REM, 32'd7, 32'hffff_fffe);
		send_op(CMD_DIV, INT_MIN, 32'd1);
		send_op(3'd5, 32'd1, 32'd1);
		send_op(3'd6, INT_MAX, INT_MIN);
		send_op(3'd7, MINUS_ONE, MINUS_ONE);
		send_op(CMD_DIV, corners[$urandom_range(0, 5)], corners[$urandom_range(0, 5)]);
	endtask

	task automatic test_random_ops(int count);
		logic [2:0] op;
		repeat (count) begin
			op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			send_op(op, pick_operand(), pick_operand());
		end
	endtask

	// receiver holds off long enough for the pipeline to fill and push back
	task automatic test_backpressure_fill();
		in_valid <= 1'b0;
		@(negedge clk);
		hold_off_cycles = 3 * LATENCY;
		test_random_ops(60);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_corners();
		random_stall = 1'b1;
		test_random_ops(1000);
		test_backpressure_fill();
		random_stall = 1'b0;
		test_random_ops(300);
		random_stall = 1'b1;
		test_random_ops(650);
		drain_results();
		$display("covered %0d transfers in, %0d results checked, with corners,", sent_count,
			checked_count);
		$display("random stalls on both sides and a long output hold-off");
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
